// ===== src/line_raster_bresenham_assert.svh =====
// ----------------------------------------------------------------------------
// Line raster assertion macros
// Shared concurrent-assertion forms for the line rasterizer.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTER_BRESENHAM_ASSERT_SVH
`define LINE_RASTER_BRESENHAM_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define LRB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line raster check failed");

// Next-cycle implication, quiet during reset.
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line raster check failed");

`endif

// ===== src/lrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Line raster package
// Types, widths and register codes shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrb_pkg;

   localparam int CANVAS_MAX   = 64;
   localparam int COORD_W      = 6;
   localparam int DIM_W        = 7;
   localparam int ADDR_W       = 12;
   localparam int COLOR_W      = 8;
   localparam int CSR_INDEX_W  = 8;
   localparam int P_W          = COORD_W + 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_CANVAS_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CANVAS_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(CANVAS_MAX);

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [ADDR_W-1:0]  pixel_address;
      logic               inside_res;
      logic [COLOR_W-1:0] pixel_red;
      logic [COLOR_W-1:0] pixel_green;
      logic [COLOR_W-1:0] pixel_blue;
      logic               last_pixel;
   } rsp_type;

   // One classified line, ready for the stepper.
   typedef struct packed {
      logic                  major_x;
      logic                  minor_neg;
      logic [COORD_W-1:0]    x0;
      logic [COORD_W-1:0]    y0;
      logic [COORD_W-1:0]    major_len;
      logic [COORD_W-1:0]    minor_len;
      logic signed [P_W-1:0] p0;
      logic [COLOR_W-1:0]    red;
      logic [COLOR_W-1:0]    green;
      logic [COLOR_W-1:0]    blue;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DRAW
   } state_type;

endpackage

// ===== src/lrb_front.sv =====
// ----------------------------------------------------------------------------
// Line raster front end
// Accepts line commands and classifies them into stepper jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrb_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lrb_pkg::req_type      req_data,
   input  lrb_pkg::q_status_type q_stat,
   output logic                  push,
   output lrb_pkg::job_type      job
);

   logic [lrb_pkg::COORD_W-1:0] adx;
   logic [lrb_pkg::COORD_W-1:0] ady;
   logic                        major_x;
   logic                        swap;
   logic [lrb_pkg::COORD_W-1:0] sx;
   logic [lrb_pkg::COORD_W-1:0] sy;
   logic [lrb_pkg::COORD_W-1:0] ex;
   logic [lrb_pkg::COORD_W-1:0] ey;
   logic [lrb_pkg::COORD_W-1:0] major_len;
   logic [lrb_pkg::COORD_W-1:0] minor_len;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      adx = (req_data.end_x > req_data.start_x) ? req_data.end_x - req_data.start_x
                                                : req_data.start_x - req_data.end_x;
      ady = (req_data.end_y > req_data.start_y) ? req_data.end_y - req_data.start_y
                                                : req_data.start_y - req_data.end_y;
      major_x = ady < adx;
      // Order endpoints so the major axis steps upward.
      swap = major_x ? (req_data.start_x > req_data.end_x)
                     : (req_data.start_y > req_data.end_y);
      sx = swap ? req_data.end_x   : req_data.start_x;
      sy = swap ? req_data.end_y   : req_data.start_y;
      ex = swap ? req_data.start_x : req_data.end_x;
      ey = swap ? req_data.start_y : req_data.end_y;
      major_len = major_x ? adx : ady;
      minor_len = major_x ? ady : adx;

      job.major_x   = major_x;
      job.minor_neg = major_x ? (ey < sy) : (ex < sx);
      job.x0        = sx;
      job.y0        = sy;
      job.major_len = major_len;
      job.minor_len = minor_len;
      job.p0        = $signed({2'b00, minor_len, 1'b0}) - $signed({3'b000, major_len});
      job.red       = req_data.red;
      job.green     = req_data.green;
      job.blue      = req_data.blue;
   end

endmodule

// ===== src/lrb_queue.sv =====
// ----------------------------------------------------------------------------
// Line raster job queue
// Short register queue between the front end and the stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lrb_pkg::job_type      push_data,
   input  logic                  pop,
   output lrb_pkg::job_type      head,
   output lrb_pkg::q_status_type q_stat
);

   lrb_pkg::job_type               entry_ff [lrb_pkg::QUEUE_DEPTH];
   logic [lrb_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [lrb_pkg::QPTR_W-1:0]     wr_ptr_in;
   logic [lrb_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [lrb_pkg::QPTR_W-1:0]     rd_ptr_in;
   logic [lrb_pkg::QCNT_W-1:0]     count_ff;
   logic [lrb_pkg::QCNT_W-1:0]     count_in;
   logic                           do_push;
   logic                           do_pop;

   assign q_stat.full  = (count_ff == lrb_pkg::QCNT_W'(lrb_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !q_stat.full;
      do_pop    = pop && !q_stat.empty;
      // Depth is a power of two: pointers wrap on their own.
      wr_ptr_in = do_push ? lrb_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? lrb_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = lrb_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = lrb_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/lrb_back.sv =====
// ----------------------------------------------------------------------------
// Line raster stepper
// Walks one queued line a pixel per cycle while the output is not stalled, and registers each pixel write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lrb_pkg::DIM_W-1:0]   width,
   input  logic [lrb_pkg::DIM_W-1:0]   height,
   input  lrb_pkg::q_status_type       q_stat,
   input  lrb_pkg::job_type            head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lrb_pkg::rsp_type            rsp_data
);

   lrb_pkg::state_type                 state_ff;
   lrb_pkg::state_type                 state_in;
   logic                               major_x_ff;
   logic                               minor_neg_ff;
   logic [lrb_pkg::COORD_W-1:0]        major_len_ff;
   logic [lrb_pkg::COORD_W-1:0]        minor_len_ff;
   logic [lrb_pkg::COLOR_W-1:0]        red_ff;
   logic [lrb_pkg::COLOR_W-1:0]        green_ff;
   logic [lrb_pkg::COLOR_W-1:0]        blue_ff;
   logic [lrb_pkg::COORD_W-1:0]        x_ff;
   logic [lrb_pkg::COORD_W-1:0]        x_in;
   logic [lrb_pkg::COORD_W-1:0]        y_ff;
   logic [lrb_pkg::COORD_W-1:0]        y_in;
   logic signed [lrb_pkg::P_W-1:0]     p_ff;
   logic signed [lrb_pkg::P_W-1:0]     p_in;
   logic [lrb_pkg::COORD_W-1:0]        left_ff;
   logic [lrb_pkg::COORD_W-1:0]        left_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   lrb_pkg::rsp_type                   rsp_data_ff;
   lrb_pkg::rsp_type                   pixel;
   logic                               load;
   logic                               advance;
   logic                               out_free;
   logic                               minor_step;
   logic [lrb_pkg::COORD_W-1:0]        minor_cur;
   logic [lrb_pkg::COORD_W-1:0]        minor_next;
   logic signed [lrb_pkg::P_W-1:0]     two_minor;
   logic signed [lrb_pkg::P_W-1:0]     two_diff;
   logic [lrb_pkg::DIM_W-1:0]          row;
   logic [2*lrb_pkg::DIM_W-1:0]        addr_full;
   logic                               on_canvas;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrb_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = lrb_pkg::ST_DRAW;
            end
         end
         lrb_pkg::ST_DRAW: begin
            if (out_free && left_ff == '0) begin
               state_in = lrb_pkg::ST_IDLE;
            end
         end
         default: state_in = lrb_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      load    = 1'b0;
      advance = 1'b0;
      case (state_ff)
         lrb_pkg::ST_IDLE: load    = !q_stat.empty;
         lrb_pkg::ST_DRAW: advance = out_free;
         default: begin
            load    = 1'b0;
            advance = 1'b0;
         end
      endcase
   end

   assign pop = load;

   // Decision term and next point.
   always_comb begin
      two_minor  = $signed({2'b00, minor_len_ff, 1'b0});
      two_diff   = two_minor - $signed({2'b00, major_len_ff, 1'b0});
      minor_step = (p_ff >= 0);
      minor_cur  = major_x_ff ? y_ff : x_ff;
      minor_next = minor_cur;
      if (minor_step) begin
         minor_next = minor_neg_ff ? lrb_pkg::COORD_W'(minor_cur - 1'b1)
                                   : lrb_pkg::COORD_W'(minor_cur + 1'b1);
      end
      p_in = minor_step ? p_ff + two_diff : p_ff + two_minor;
      if (major_x_ff) begin
         x_in = lrb_pkg::COORD_W'(x_ff + 1'b1);
         y_in = minor_next;
      end else begin
         x_in = minor_next;
         y_in = lrb_pkg::COORD_W'(y_ff + 1'b1);
      end
      left_in = lrb_pkg::COORD_W'(left_ff - 1'b1);
   end

   // Pixel write for the current point.
   always_comb begin
      on_canvas = ({1'b0, x_ff} < width) && ({1'b0, y_ff} < height);
      row       = lrb_pkg::DIM_W'(height - {1'b0, y_ff} - 1'b1);
      addr_full = {{lrb_pkg::DIM_W{1'b0}}, row} * {{lrb_pkg::DIM_W{1'b0}}, width}
                + {{(lrb_pkg::DIM_W + 1){1'b0}}, x_ff};
      pixel.pixel_x       = x_ff;
      pixel.pixel_y       = y_ff;
      pixel.pixel_address = on_canvas ? addr_full[lrb_pkg::ADDR_W-1:0] : '0;
      pixel.inside_res    = on_canvas;
      pixel.pixel_red     = red_ff;
      pixel.pixel_green   = green_ff;
      pixel.pixel_blue    = blue_ff;
      pixel.last_pixel    = (left_ff == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         major_x_ff   <= head.major_x;
         minor_neg_ff <= head.minor_neg;
         major_len_ff <= head.major_len;
         minor_len_ff <= head.minor_len;
         red_ff       <= head.red;
         green_ff     <= head.green;
         blue_ff      <= head.blue;
         x_ff         <= head.x0;
         y_ff         <= head.y0;
         p_ff         <= head.p0;
         left_ff      <= head.major_len;
      end else if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         p_ff    <= p_in;
         left_ff <= left_in;
      end
      if (advance) begin
         rsp_data_ff <= pixel;
      end
   end

endmodule

// ===== src/line_raster_bresenham.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer (integer Bresenham)
// Turns line commands into an ordered stream of pixel writes.
// ----------------------------------------------------------------------------
// A command carries two endpoints and an RGB color; the block answers with
// max(|dx|,|dy|)+1 pixel transfers, walking the major axis upward one pixel per
// cycle, each tagged with its frame address (height-1-y)*width+x, an inside
// flag (address 0 when outside the canvas) and a last flag on the final pixel.
// Each line is first loaded from the two-entry job queue into the idle
// stepper, then walked one pixel per cycle; the stepper's single point
// register takes no new command until the last pixel of the current line
// is registered. The front end classifies and queues up to two further
// commands while a line is drawn. A registered output stage holds each
// finished pixel, and the stepper pauses while that pixel waits for its
// transfer. Canvas width and height are written through the csr_ port,
// by the user only while the block is idle (the block does not enforce
// it); values above 64 act as 64 and unknown register indexes are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "line_raster_bresenham_assert.svh"

module line_raster_bresenham (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lrb_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lrb_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lrb_pkg::DIM_W-1:0]         csr_wdata
);

   logic [lrb_pkg::DIM_W-1:0] width_ff;
   logic [lrb_pkg::DIM_W-1:0] width_in;
   logic [lrb_pkg::DIM_W-1:0] height_ff;
   logic [lrb_pkg::DIM_W-1:0] height_in;
   logic [lrb_pkg::DIM_W-1:0] width_eff;
   logic [lrb_pkg::DIM_W-1:0] height_eff;
   logic                      csr_write;
   logic                      push;
   logic                      pop;
   lrb_pkg::job_type          front_job;
   lrb_pkg::job_type          head_job;
   lrb_pkg::q_status_type     q_stat;

   // Register writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            lrb_pkg::REG_CANVAS_WIDTH:  width_in  = csr_wdata;
            lrb_pkg::REG_CANVAS_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lrb_pkg::DIM_RESET;
         height_ff <= lrb_pkg::DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamp oversized canvas settings to the largest frame.
   assign width_eff  = (width_ff > lrb_pkg::DIM_RESET) ? lrb_pkg::DIM_RESET : width_ff;
   assign height_eff = (height_ff > lrb_pkg::DIM_RESET) ? lrb_pkg::DIM_RESET : height_ff;

   // Classify incoming commands.
   lrb_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .job       (front_job)
   );

   // Hold classified commands until the stepper is free.
   lrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_job),
      .pop       (pop),
      .head      (head_job),
      .q_stat    (q_stat)
   );

   // Step each line and emit pixel transfers.
   lrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .width     (width_eff),
      .height    (height_eff),
      .q_stat    (q_stat),
      .head      (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A pixel flagged inside lies within the clamped canvas.
   `LRB_ASSERT_NOW(a_inside_bounds, clock, reset, rsp_valid && rsp_data.inside_res, ({1'b0, rsp_data.pixel_x} < width_eff) && ({1'b0, rsp_data.pixel_y} < height_eff))
   // Off-canvas pixels carry address zero.
   `LRB_ASSERT_NOW(a_outside_addr, clock, reset, rsp_valid && !rsp_data.inside_res, rsp_data.pixel_address == '0)
   // The queue is never full and empty at once.
   `LRB_ASSERT_NOW(a_queue_status, clock, reset, 1'b1, !(q_stat.full && q_stat.empty))
   // A stalled pixel stays offered and unchanged.
   `LRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Sends line commands, predicts every pixel transfer and checks it in order.
// ----------------------------------------------------------------------------
// A software Bresenham stepper runs beside the block. Each accepted command is
// expanded into the pixel transfers it must cause, under the canvas size
// programmed at the time. A checker compares every result transfer, field by
// field, with the oldest pending pixel. The stimulus has four parts:
//   - directed lines on the default canvas: single points, full-length rows
//     and columns, diagonals, swapped endpoints, zero decision terms, color
//     extremes
//   - canvas register writes: clipping, a 1x1 canvas, a zero canvas, values
//     above the maximum and writes to unmapped indexes
//   - random lines in phases with different canvas sizes and idle patterns
//   - a long output hold while commands keep coming, so the block backs up
// A watchdog ends the run when no transfer happens for too long.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   // Register indexes the block has no register behind.
   localparam logic [lrb_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_LOW  = lrb_pkg::CSR_INDEX_W'(2);
   localparam logic [lrb_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED_HIGH = lrb_pkg::CSR_INDEX_W'(255);

   localparam int RANDOM_PHASES   = 5;
   localparam int LINES_PER_PHASE = 44;
   localparam int LONG_HOLD       = 200;   // output hold for the backpressure test
   localparam int SETTLE_CYCLES   = 80;    // longer than one full-length line
   localparam int IDLE_LIMIT      = 1000;  // cycles without any transfer

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   lrb_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   lrb_pkg::rsp_type                rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [lrb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lrb_pkg::DIM_W-1:0]       csr_wdata;

   // Shadow copy of the canvas registers, as the block should hold them.
   logic [lrb_pkg::DIM_W-1:0] canvas_w = lrb_pkg::DIM_RESET;
   logic [lrb_pkg::DIM_W-1:0] canvas_h = lrb_pkg::DIM_RESET;

   // Pixels predicted for accepted commands, oldest first.
   lrb_pkg::rsp_type pending_pixels[$];

   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int unsigned rsp_hold_request = 0;

   int unsigned mismatches      = 0;
   int unsigned lines_sent      = 0;
   int unsigned pixels_seen     = 0;
   int unsigned clipped_pixels  = 0;
   int unsigned canvas_settings = 1;
   int unsigned idle_cycles     = 0;

   line_raster_bresenham dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Pixel prediction
   // -------------------------------------------------------------------------

   // Walk the line the way the block must: pick the major axis (ties go to y),
   // swap endpoints so the major axis counts up, and step the minor axis by
   // one whenever the decision term is zero or positive.
   function automatic void raster_line(input lrb_pkg::req_type cmd);
      int x0, y0, x1, y1, adx, ady, swap_tmp;
      int steps, dir, p, x, y, w, h, ux, uy, n;
      bit along_x;
      lrb_pkg::rsp_type px;
      x0 = cmd.start_x;
      y0 = cmd.start_y;
      x1 = cmd.end_x;
      y1 = cmd.end_y;
      adx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ady = (y1 > y0) ? y1 - y0 : y0 - y1;
      along_x = ady < adx;
      if (along_x ? (x0 > x1) : (y0 > y1)) begin
         swap_tmp = x0; x0 = x1; x1 = swap_tmp;
         swap_tmp = y0; y0 = y1; y1 = swap_tmp;
      end
      if (along_x) begin
         dir   = (y1 < y0) ? -1 : 1;
         steps = adx + 1;
         p     = 2 * ady - adx;
      end else begin
         dir   = (x1 < x0) ? -1 : 1;
         steps = ady + 1;
         p     = 2 * adx - ady;
      end
      // Register values above the maximum act as the maximum.
      w = (canvas_w > lrb_pkg::CANVAS_MAX) ? lrb_pkg::CANVAS_MAX : canvas_w;
      h = (canvas_h > lrb_pkg::CANVAS_MAX) ? lrb_pkg::CANVAS_MAX : canvas_h;
      x = x0;
      y = y0;
      for (n = 0; n < steps; n++) begin
         ux = x & 63;
         uy = y & 63;
         px.pixel_x       = lrb_pkg::COORD_W'(ux);
         px.pixel_y       = lrb_pkg::COORD_W'(uy);
         px.inside_res    = (ux < w) && (uy < h);
         // Rows count from the bottom; clipped pixels carry address zero.
         px.pixel_address = px.inside_res ? lrb_pkg::ADDR_W'((h - 1 - uy) * w + ux) : '0;
         px.pixel_red     = cmd.red;
         px.pixel_green   = cmd.green;
         px.pixel_blue    = cmd.blue;
         px.last_pixel    = (n == steps - 1);
         pending_pixels.push_back(px);
         if (along_x) begin
            if (p < 0) begin
               p += 2 * ady;
            end else begin
               y += dir;
               p += 2 * ady - 2 * adx;
            end
            x += 1;
         end else begin
            if (p < 0) begin
               p += 2 * adx;
            end else begin
               x += dir;
               p += 2 * adx - 2 * ady;
            end
            y += 1;
         end
      end
   endfunction

   function automatic lrb_pkg::req_type make_line(input int x0, input int y0, input int x1,
                                                  input int y1, input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b);
      lrb_pkg::req_type cmd;
      cmd.start_x = lrb_pkg::COORD_W'(x0);
      cmd.start_y = lrb_pkg::COORD_W'(y0);
      cmd.end_x   = lrb_pkg::COORD_W'(x1);
      cmd.end_y   = lrb_pkg::COORD_W'(y1);
      cmd.red     = r;
      cmd.green   = g;
      cmd.blue    = b;
      return cmd;
   endfunction

   // -------------------------------------------------------------------------
   // Driving
   // -------------------------------------------------------------------------

   // Offer one command after a random gap and hold it until the transfer.
   // Valid is lowered only for a gap, so back-to-back commands keep it high.
   task automatic send_line(input lrb_pkg::req_type cmd);
      int unsigned gap;
      gap = send_idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
      raster_line(cmd);
      lines_sent++;
   endtask

   // Drop valid and wait until every predicted pixel has arrived.
   task automatic drain_lines();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Write one register and mirror it; the caller drops valid after a group.
   task automatic csr_put(input logic [lrb_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [lrb_pkg::DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == lrb_pkg::REG_CANVAS_WIDTH) begin
         canvas_w = val;
      end else if (idx == lrb_pkg::REG_CANVAS_HEIGHT) begin
         canvas_h = val;
      end
   endtask

   // Only called with the block idle: after reset or after drain_lines.
   task automatic set_canvas(input logic [lrb_pkg::DIM_W-1:0] w,
                             input logic [lrb_pkg::DIM_W-1:0] h);
      csr_put(lrb_pkg::REG_CANVAS_WIDTH, w);
      csr_put(lrb_pkg::REG_CANVAS_HEIGHT, h);
      csr_valid <= 1'b0;
      canvas_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   task automatic test_default_canvas();
      send_line(make_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00));     // single point at origin
      send_line(make_line(63, 63, 63, 63, 8'hFF, 8'hFF, 8'hFF)); // single point at far corner
      send_line(make_line(0, 10, 63, 10, 8'hAA, 8'h55, 8'hAA)); // full-width row
      send_line(make_line(20, 63, 20, 0, 8'h55, 8'hAA, 8'h55));  // full column, swapped
      send_line(make_line(0, 0, 63, 63, 8'h12, 8'h34, 8'h56));   // diagonal, tie steps along y
      send_line(make_line(0, 63, 63, 0, 8'hFE, 8'h01, 8'h80));   // anti-diagonal
      send_line(make_line(40, 5, 2, 30, 8'h7F, 8'h80, 8'h01));   // shallow, swapped, y falls
      send_line(make_line(7, 50, 12, 3, 8'h01, 8'hFE, 8'h7F));   // steep, swapped, x falls
      send_line(make_line(0, 0, 2, 1, 8'hC3, 8'h3C, 8'h99));     // decision term starts at zero
      send_line(make_line(14, 7, 10, 5, 8'h3C, 8'hC3, 8'h66));   // same, swapped endpoints
      send_line(make_line(33, 1, 34, 62, 8'h0F, 8'hF0, 8'h5A));  // nearly vertical
      drain_lines();
   endtask

   task automatic test_canvas_registers();
      // Small canvas: lines cross the right and top edges.
      set_canvas(7'd20, 7'd10);
      send_line(make_line(5, 2, 30, 15, 8'h11, 8'h22, 8'h33));
      send_line(make_line(19, 9, 20, 10, 8'h44, 8'h55, 8'h66));
      drain_lines();
      // Smallest canvas: only the origin is inside.
      set_canvas(7'd1, 7'd1);
      send_line(make_line(0, 0, 1, 1, 8'h77, 8'h88, 8'h99));
      send_line(make_line(3, 0, 0, 0, 8'hAA, 8'hBB, 8'hCC));
      drain_lines();
      // Zero canvas: nothing is inside.
      set_canvas(7'd0, 7'd0);
      send_line(make_line(0, 0, 5, 5, 8'hDD, 8'hEE, 8'hFF));
      drain_lines();
      // Values above the maximum act as the maximum.
      set_canvas(7'd127, 7'd100);
      send_line(make_line(60, 62, 63, 63, 8'h01, 8'h02, 8'h04));
      send_line(make_line(0, 63, 63, 63, 8'h08, 8'h10, 8'h20));
      drain_lines();
      // Unmapped indexes must leave both registers alone.
      csr_put(REG_UNMAPPED_LOW, 7'd5);
      csr_put(REG_UNMAPPED_HIGH, 7'h7F);
      csr_valid <= 1'b0;
      send_line(make_line(63, 0, 0, 63, 8'h40, 8'h80, 8'hC0));
      drain_lines();
      // Full-width single-row canvas, then a tall narrow one.
      set_canvas(7'd64, 7'd1);
      send_line(make_line(0, 0, 63, 2, 8'h5A, 8'hA5, 8'h00));
      drain_lines();
      set_canvas(7'd3, 7'd64);
      send_line(make_line(10, 40, 0, 30, 8'hA5, 8'h5A, 8'hFF));
      drain_lines();
   endtask

   // Random commands in phases; the canvas changes only between phases, and
   // each phase sets whether the sender and the receiver idle, one with none at all.
   task automatic test_random_lines();
      lrb_pkg::req_type cmd;
      int phase, k;
      logic [lrb_pkg::DIM_W-1:0] w, h;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               w = lrb_pkg::DIM_RESET;
               h = lrb_pkg::DIM_RESET;
            end
            1, 2: begin
               w = lrb_pkg::DIM_W'($urandom_range(1, lrb_pkg::CANVAS_MAX));
               h = lrb_pkg::DIM_W'($urandom_range(1, lrb_pkg::CANVAS_MAX));
            end
            3: begin
               w = lrb_pkg::DIM_W'($urandom_range(1, 8));
               h = lrb_pkg::DIM_W'($urandom_range(50, 127));
            end
            default: begin
               w = lrb_pkg::DIM_W'($urandom_range(0, 127));
               h = lrb_pkg::DIM_W'($urandom_range(0, 127));
            end
         endcase
         set_canvas(w, h);
         send_idle_on = (phase == 0) || (phase == 2) || (phase == 4);
         recv_idle_on = (phase != 1) && (phase != 2);
         for (k = 0; k < LINES_PER_PHASE; k++) begin
            cmd.start_x = lrb_pkg::COORD_W'($urandom);
            cmd.start_y = lrb_pkg::COORD_W'($urandom);
            cmd.end_x   = lrb_pkg::COORD_W'($urandom);
            cmd.end_y   = lrb_pkg::COORD_W'($urandom);
            cmd.red     = lrb_pkg::COLOR_W'($urandom);
            cmd.green   = lrb_pkg::COLOR_W'($urandom);
            cmd.blue    = lrb_pkg::COLOR_W'($urandom);
            // Keep about half the lines short so more commands fit the run.
            if ($urandom_range(0, 1) == 0) begin
               cmd.end_x = cmd.start_x + lrb_pkg::COORD_W'($urandom_range(0, 14))
                         - lrb_pkg::COORD_W'(7);
               cmd.end_y = cmd.start_y + lrb_pkg::COORD_W'($urandom_range(0, 14))
                         - lrb_pkg::COORD_W'(7);
            end
            send_line(cmd);
         end
         drain_lines();
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // Hold the output for a long stretch while commands keep coming, so the
   // job queue fills and the block stalls its input; then pause the sender
   // until every pixel is out.
   task automatic test_output_backpressure();
      lrb_pkg::req_type cmd;
      int k;
      set_canvas(lrb_pkg::DIM_RESET, lrb_pkg::DIM_RESET);
      send_idle_on = 1'b0;
      rsp_hold_request = LONG_HOLD;
      for (k = 0; k < 10; k++) begin
         cmd = make_line(k, 2 * k, k + 3, 2 * k + 1, lrb_pkg::COLOR_W'($urandom),
                         lrb_pkg::COLOR_W'($urandom), lrb_pkg::COLOR_W'($urandom));
         send_line(cmd);
      end
      drain_lines();
      send_idle_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Result side
   // -------------------------------------------------------------------------

   // Receiver: before each result, hold stall for a random number of cycles when
   // idling is on, or for the long stretch a test has asked for.
   initial begin : pixel_sink
      int unsigned pause;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         pause = rsp_hold_request;
         if (pause != 0) begin
            rsp_hold_request = 0;
         end else if (recv_idle_on) begin
            pause = $urandom_range(0, 8);
         end
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Compare each pixel transfer with the oldest prediction.
   always @(posedge clock) begin : pixel_check
      lrb_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         pixels_seen++;
         if (rsp_data.inside_res !== 1'b1) clipped_pixels++;
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel transfer with none pending, expected nothing, got x=%0d y=%0d",
                     $time, rsp_data.pixel_x, rsp_data.pixel_y);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_x", 16'(want.pixel_x), 16'(rsp_data.pixel_x));
            check_field("pixel_y", 16'(want.pixel_y), 16'(rsp_data.pixel_y));
            check_field("pixel_address", 16'(want.pixel_address),
                        16'(rsp_data.pixel_address));
            check_field("inside_res", 16'(want.inside_res), 16'(rsp_data.inside_res));
            check_field("pixel_red", 16'(want.pixel_red), 16'(rsp_data.pixel_red));
            check_field("pixel_green", 16'(want.pixel_green), 16'(rsp_data.pixel_green));
            check_field("pixel_blue", 16'(want.pixel_blue), 16'(rsp_data.pixel_blue));
            check_field("last_pixel", 16'(want.last_pixel), 16'(rsp_data.last_pixel));
         end
      end
   end

   // Watchdog: count cycles in which no channel completes a transfer.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d pixels still pending",
                  $time, idle_cycles, pending_pixels.size());
         $display("testbench failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_default_canvas();
      test_canvas_registers();
      test_random_lines();
      test_output_backpressure();

      // Leave room for any stray pixel after the last expected one.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Drew %0d lines as %0d pixel transfers, %0d of them clipped,",
               lines_sent, pixels_seen, clipped_pixels);
      $display("over %0d canvas sizes with random idling and one long output hold.",
               canvas_settings);
      if (mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
